// File: rtl/priority_timeslice_scheduler_defines.svh
// Assertion helpers for the priority time-slice scheduler.
// PTS_ASSERT_IMP: same-cycle implication. PTS_ASSERT_NXT: next-cycle implication.
`ifndef PRIORITY_TIMESLICE_SCHEDULER_DEFINES_SVH
`define PRIORITY_TIMESLICE_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pts assertion failed");
`define PTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pts assertion failed");
`else
`define PTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/pts_pkg.sv
package pts_pkg;

    // Parameter defaults
    localparam int NUM_SLOTS_DEF  = 16;
    localparam int PRIO_BITS_DEF  = 8;
    localparam int SLICE_BITS_DEF = 16;

    // Request kinds carried in tuser
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_SET   = 2'd2;

    // Fixed field widths on the ports
    localparam int SLOT_FW  = 4;
    localparam int PRIO_FW  = 8;
    localparam int SLICE_FW = 16;

    // Input tdata layout
    localparam int IN_SLOT_LSB  = 0;
    localparam int IN_PRES_BIT  = 4;
    localparam int IN_SUSP_BIT  = 5;
    localparam int IN_PRIO_LSB  = 6;
    localparam int IN_SLICE_LSB = 14;

    localparam int IN_TDATA_W   = 32;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_TUSER_W  = 1;

    typedef struct packed {
        logic accept;
        logic rd_cur;
        logic do_write;
        logic do_set;
        logic charge;
        logic scan_rd;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       scan_last;
        logic       out_free;
    } t_status;

endpackage

// File: rtl/priority_timeslice_scheduler.sv
// Priority time-slice scheduler.
// Slave stream (s_axis_*): one request per transfer; tuser holds the request kind
// (tick, write slot, set running slot), tdata the slot number and slot contents.
// Master stream (m_axis_*): one result per request, the running slot afterwards
// in tdata and a rescheduled flag in tuser.
// A write, set or unused request passes through decode and hand-off; a tick passes
// through decode, charge, a scan of the other NUM_SLOTS - 1 slots, drain and hand-off.
// The slot table is a single-read-port memory, so the charge of the running slot and
// the scan go one slot per cycle.
// One request is in work at a time; s_axis_tready is high only while idle, so the
// next transfer waits until the result of the previous request has been loaded into
// the output register. The next request is taken while the previous result still
// waits on the master side.
// A stalled receiver holds the result in the output register; a finished request
// waits there until the register frees, then the block goes idle again.
// Reset (synchronous, active low) empties the slot table through its valid bits,
// selects slot 0 as running and drops m_axis_tvalid; no clearing pass is needed.
`include "priority_timeslice_scheduler_defines.svh"

module priority_timeslice_scheduler #(
    parameter int NUM_SLOTS  = pts_pkg::NUM_SLOTS_DEF,
    parameter int PRIO_BITS  = pts_pkg::PRIO_BITS_DEF,
    parameter int SLICE_BITS = pts_pkg::SLICE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot[3:0], present[4], suspended[5], prio_in[13:6], slice_in[29:14], zero[31:30]
    input  logic [pts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [pts_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // running_slot[3:0], zero[7:4]
    output logic [pts_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // rescheduled[0]
    output logic [pts_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    pts_pkg::t_cmd    w_cmd;
    pts_pkg::t_status w_status;

    // Sequencer: decode, charge, scan, commit, hand off
    pts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Slot table, running slot, best-so-far tracking and output register
    pts_dpath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .PRIO_BITS  (PRIO_BITS),
        .SLICE_BITS (SLICE_BITS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

    // One request in work: a transfer closes the input until the result is handed off
    `PTS_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A result never overwrites one still waiting on the master side
    `PTS_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.out_load, !m_axis_tvalid || m_axis_tready)
    // Selection is committed only for a tick
    `PTS_ASSERT_IMP(a_commit_on_tick, i_clk, i_rst_n, w_cmd.commit, w_status.req_type == pts_pkg::REQ_TICK)
    // A new result appears only from the sequencer's hand-off
    `PTS_ASSERT_IMP(a_valid_from_load, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_cmd.out_load))

endmodule

// File: rtl/pts_ctrl.sv
module pts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pts_pkg::t_status i_status,
    output pts_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_CHARGE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                // fetch the running slot's entry; only a tick uses it
                o_cmd.rd_cur = 1'b1;
                unique case (i_status.req_type)
                    pts_pkg::REQ_TICK: begin
                        n_state = S_CHARGE;
                    end
                    pts_pkg::REQ_WRITE: begin
                        o_cmd.do_write = 1'b1;
                        n_state        = S_DONE;
                    end
                    pts_pkg::REQ_SET: begin
                        o_cmd.do_set = 1'b1;
                        n_state      = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CHARGE: begin
                o_cmd.charge = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.commit = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// File: rtl/pts_dpath.sv
module pts_dpath #(
    parameter int NUM_SLOTS  = pts_pkg::NUM_SLOTS_DEF,
    parameter int PRIO_BITS  = pts_pkg::PRIO_BITS_DEF,
    parameter int SLICE_BITS = pts_pkg::SLICE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [pts_pkg::IN_TDATA_W-1:0]     i_tdata,
    input  logic [pts_pkg::IN_TUSER_W-1:0]     i_tuser,
    input  logic                               i_ready,
    output logic                               o_valid,
    output logic [pts_pkg::OUT_TDATA_W-1:0]    o_tdata,
    output logic [pts_pkg::OUT_TUSER_W-1:0]    o_tuser,
    input  pts_pkg::t_cmd                      i_cmd,
    output pts_pkg::t_status                   o_status
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int ENT_W  = 2 + PRIO_BITS + SLICE_BITS;
    localparam int SIDX_W = (SLOT_W > pts_pkg::SLOT_FW) ? SLOT_W : pts_pkg::SLOT_FW;
    localparam int PIN_W  = (PRIO_BITS > pts_pkg::PRIO_FW) ? PRIO_BITS : pts_pkg::PRIO_FW;
    localparam int SIN_W  = (SLICE_BITS > pts_pkg::SLICE_FW) ? SLICE_BITS : pts_pkg::SLICE_FW;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] a);
        return (a == SLOT_W'(NUM_SLOTS - 1)) ? '0 : a + 1'b1;
    endfunction

    // Latched request
    logic [1:0]                  r_req_type;
    logic [pts_pkg::SLOT_FW-1:0] r_slot;
    logic                        r_present;
    logic                        r_susp;
    logic [pts_pkg::PRIO_FW-1:0] r_prio;
    logic [pts_pkg::SLICE_FW-1:0] r_slice;

    // Slot table, valid bits cleared by reset
    logic [ENT_W-1:0]     mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    logic [ENT_W-1:0]     r_rd_data;
    logic                 r_rd_hit;

    logic [SLOT_W-1:0]    r_cur;
    logic [SLOT_W-1:0]    r_scan_idx;
    logic [SLOT_W-1:0]    r_scan_cnt;
    logic [SLOT_W-1:0]    r_eval_idx;
    logic                 r_eval_pend;
    logic [SLOT_W-1:0]    r_best_idx;
    logic [PRIO_BITS-1:0] r_best_prio;
    logic [SLOT_W-1:0]    n_best_idx;
    logic [PRIO_BITS-1:0] n_best_prio;

    logic                        r_out_valid;
    logic [pts_pkg::SLOT_FW-1:0] r_out_slot;
    logic                        r_out_resched;

    logic [SIDX_W-1:0]     w_slot_ext;
    logic [SLOT_W-1:0]     w_slot_idx;
    logic                  w_slot_ok;
    logic [PIN_W-1:0]      w_prio_ext;
    logic [SIN_W-1:0]      w_slice_ext;
    logic [SIDX_W-1:0]     w_cur_ext;

    logic [ENT_W-1:0]      w_ent;
    logic                  w_ent_pres;
    logic                  w_ent_susp;
    logic [PRIO_BITS-1:0]  w_ent_prio;
    logic [SLICE_BITS-1:0] w_ent_slice;
    logic [PRIO_BITS-1:0]  w_chg_prio;
    logic [SLICE_BITS-1:0] w_chg_slice;

    logic                  w_we;
    logic [SLOT_W-1:0]     w_waddr;
    logic [ENT_W-1:0]      w_wdata;
    logic [SLOT_W-1:0]     w_raddr;
    logic                  w_re;

    assign w_slot_ext  = SIDX_W'(r_slot);
    assign w_slot_idx  = w_slot_ext[SLOT_W-1:0];
    assign w_slot_ok   = (32'(r_slot) < 32'(NUM_SLOTS));
    assign w_prio_ext  = PIN_W'(r_prio);
    assign w_slice_ext = SIN_W'(r_slice);
    assign w_cur_ext   = SIDX_W'(r_cur);

    // Entry read back; a never-written slot reads as all zero
    assign w_ent       = r_rd_hit ? r_rd_data : '0;
    assign w_ent_pres  = w_ent[ENT_W-1];
    assign w_ent_susp  = w_ent[ENT_W-2];
    assign w_ent_prio  = w_ent[SLICE_BITS +: PRIO_BITS];
    assign w_ent_slice = w_ent[SLICE_BITS-1:0];

    // Charge the running slot: spend one tick, or drop priority when spent
    assign w_chg_slice = (w_ent_slice != '0) ? w_ent_slice - 1'b1 : w_ent_slice;
    assign w_chg_prio  = (w_ent_slice != '0) ? w_ent_prio : '0;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_slot_idx;
        w_wdata = {r_present, r_susp, w_prio_ext[PRIO_BITS-1:0],
                   w_slice_ext[SLICE_BITS-1:0]};
        if (i_cmd.do_write && w_slot_ok) begin
            w_we = 1'b1;
        end else if (i_cmd.charge) begin
            w_we    = 1'b1;
            w_waddr = r_cur;
            w_wdata = {w_ent_pres, w_ent_susp, w_chg_prio, w_chg_slice};
        end
    end

    assign w_raddr = i_cmd.scan_rd ? r_scan_idx : r_cur;
    assign w_re    = i_cmd.rd_cur || i_cmd.scan_rd;

    // Later slots in scan order win ties
    always_comb begin
        n_best_idx  = r_best_idx;
        n_best_prio = r_best_prio;
        if (r_eval_pend && w_ent_pres && !w_ent_susp && (w_ent_prio >= r_best_prio)) begin
            n_best_idx  = r_eval_idx;
            n_best_prio = w_ent_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rd_hit <= r_vld[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_tuser[1:0];
            r_slot     <= i_tdata[pts_pkg::IN_SLOT_LSB +: pts_pkg::SLOT_FW];
            r_present  <= i_tdata[pts_pkg::IN_PRES_BIT];
            r_susp     <= i_tdata[pts_pkg::IN_SUSP_BIT];
            r_prio     <= i_tdata[pts_pkg::IN_PRIO_LSB +: pts_pkg::PRIO_FW];
            r_slice    <= i_tdata[pts_pkg::IN_SLICE_LSB +: pts_pkg::SLICE_FW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.charge) begin
            r_best_idx  <= r_cur;
            r_best_prio <= w_chg_prio;
            r_scan_idx  <= f_next(r_cur);
            r_scan_cnt  <= SLOT_W'(NUM_SLOTS - 1);
        end else begin
            r_best_idx  <= n_best_idx;
            r_best_prio <= n_best_prio;
            if (i_cmd.scan_rd) begin
                r_scan_idx <= f_next(r_scan_idx);
                r_scan_cnt <= r_scan_cnt - 1'b1;
            end
        end
        r_eval_idx <= r_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_pend <= 1'b0;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_eval_pend <= i_cmd.scan_rd;
            if (i_cmd.do_set && w_slot_ok) begin
                r_cur <= w_slot_idx;
            end else if (i_cmd.commit) begin
                r_cur <= n_best_idx;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_slot    <= w_cur_ext[pts_pkg::SLOT_FW-1:0];
            r_out_resched <= (r_req_type == pts_pkg::REQ_TICK);
        end
    end

    assign o_valid = r_out_valid;
    assign o_tdata = pts_pkg::OUT_TDATA_W'(r_out_slot);
    assign o_tuser = r_out_resched;

    assign o_status.req_type  = r_req_type;
    assign o_status.scan_last = (r_scan_cnt == SLOT_W'(1));
    assign o_status.out_free  = !r_out_valid || i_ready;

endmodule

// File: tb/tb_top.sv
module tb_top;

    localparam int NSLOT = 16;
    // The fourth request code has no name in the package; the block must ignore it.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    // A tick runs a full scan of the slot table; allow a margin for the tail.
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        logic [1:0]  req;
        logic [3:0]  slot;
        logic        pres;
        logic        susp;
        logic [7:0]  prio;
        logic [15:0] slice;
        int          phase;
        bit          hold;     // wait until every result is back before this transfer
    } t_sched_req;

    typedef struct packed {
        logic [3:0] run_slot;
        logic       resched;
    } t_sched_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_axis_tready;
    // slot[3:0], present[4], suspended[5], prio_in[13:6], slice_in[29:14], zero[31:30]
    logic [31:0] s_tdata  = '0;
    // req_type[1:0]
    logic [1:0]  s_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_tready = 1'b0;
    // running_slot[3:0], zero[7:4]
    logic [7:0]  m_axis_tdata;
    // rescheduled[0]
    logic [0:0]  m_axis_tuser;

    always #5 i_clk = ~i_clk;

    priority_timeslice_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Idle percentages per phase: sender light / receiver heavy, then swapped, then none.
    int send_idle_pct[3] = '{24, 77, 0};
    int rcv_idle_pct[3]  = '{77, 24, 0};

    t_sched_req pend_q[$];
    t_sched_res want_q[$];
    t_sched_req drv_item;
    t_sched_res mon_want;

    int total_items = 0;
    int sent_cnt    = 0;
    int rcvd_cnt    = 0;
    int err_cnt     = 0;
    int cur_phase   = 0;
    int gen_phase   = 0;
    int idle_cycles = 0;

    int n_tick = 0, n_write = 0, n_set = 0, n_unused = 0, n_hold = 0;
    int n_moves = 0;
    logic [3:0] last_run = '0;

    // Shadow copy of the slot table and the running slot.
    bit         tbl_present [NSLOT];
    bit         tbl_susp    [NSLOT];
    logic [7:0] tbl_prio    [NSLOT];
    logic [15:0] tbl_slice  [NSLOT];
    logic [3:0] tbl_run;

    // Apply one request to the shadow table and return the result it must produce.
    function automatic t_sched_res advance_scheduler(t_sched_req r);
        t_sched_res res;
        logic [3:0] best;
        logic [3:0] idx;
        res.resched = 1'b0;
        case (r.req)
            pts_pkg::REQ_TICK: begin
                best = tbl_run;
                // Charge the running slot: burn one tick, or drop its priority once empty.
                if (tbl_slice[tbl_run] != '0)
                    tbl_slice[tbl_run] = tbl_slice[tbl_run] - 16'd1;
                else
                    tbl_prio[tbl_run] = '0;
                // Circular scan of the other slots; >= hands ties to the later slot.
                for (int k = 1; k < NSLOT; k++) begin
                    idx = tbl_run + 4'(k);
                    if (tbl_present[idx] && !tbl_susp[idx] && tbl_prio[idx] >= tbl_prio[best])
                        best = idx;
                end
                tbl_run     = best;
                res.resched = 1'b1;
            end
            pts_pkg::REQ_WRITE: begin
                tbl_present[r.slot] = r.pres;
                tbl_susp[r.slot]    = r.susp;
                tbl_prio[r.slot]    = r.prio;
                tbl_slice[r.slot]   = r.slice;
            end
            pts_pkg::REQ_SET: begin
                tbl_run = r.slot;
            end
            default: begin
            end
        endcase
        res.run_slot = tbl_run;
        return res;
    endfunction

    task automatic queue_request(input logic [1:0] req, input logic [3:0] slot,
                                 input logic pres, input logic susp,
                                 input logic [7:0] prio, input logic [15:0] slice,
                                 input bit hold);
        t_sched_req r;
        r.req   = req;
        r.slot  = slot;
        r.pres  = pres;
        r.susp  = susp;
        r.prio  = prio;
        r.slice = slice;
        r.phase = gen_phase;
        r.hold  = hold;
        pend_q.push_back(r);
        total_items++;
    endtask

    // Driver: predict on each accepted transfer, then load the next request or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_axis_tready) begin
                want_q.push_back(advance_scheduler(drv_item));
                sent_cnt <= sent_cnt + 1;
                case (drv_item.req)
                    pts_pkg::REQ_TICK:  n_tick++;
                    pts_pkg::REQ_WRITE: n_write++;
                    pts_pkg::REQ_SET:   n_set++;
                    default:            n_unused++;
                endcase
            end
            if (!s_tvalid || s_axis_tready) begin
                // Hold a flagged request back until nothing is outstanding.
                if (pend_q.size() != 0 &&
                    !(pend_q[0].hold && (sent_cnt != rcvd_cnt || s_tvalid)) &&
                    $urandom_range(99) >= send_idle_pct[pend_q[0].phase]) begin
                    drv_item = pend_q.pop_front();
                    if (drv_item.hold)
                        n_hold++;
                    cur_phase <= drv_item.phase;
                    s_tdata   <= {2'b00, drv_item.slice, drv_item.prio,
                                  drv_item.susp, drv_item.pres, drv_item.slot};
                    s_tuser   <= drv_item.req;
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid  <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rcv_idle_pct[cur_phase]);
    end

    // Monitor: compare each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            rcvd_cnt <= rcvd_cnt + 1;
            if (want_q.size() == 0) begin
                if (err_cnt < 10)
                    $display("unexpected result: running_slot %0d rescheduled %0d",
                             m_axis_tdata[3:0], m_axis_tuser[0]);
                err_cnt++;
            end else begin
                mon_want = want_q.pop_front();
                if (m_axis_tdata[3:0] !== mon_want.run_slot ||
                    m_axis_tuser[0] !== mon_want.resched) begin
                    if (err_cnt < 10)
                        $display("mismatch at result %0d: running_slot exp %0d got %0d, %s%0d got %0d",
                                 rcvd_cnt, mon_want.run_slot, m_axis_tdata[3:0],
                                 "rescheduled exp ", mon_want.resched, m_axis_tuser[0]);
                    err_cnt++;
                end
                if (mon_want.resched && mon_want.run_slot != last_run)
                    n_moves++;
                last_run = mon_want.run_slot;
            end
        end
    end

    // Watchdog: count cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stim_main
        int          sel;
        int          prev_phase;
        logic [1:0]  rq;
        logic [7:0]  pr;
        logic [15:0] sl;
        bit          hold;

        for (int s = 0; s < NSLOT; s++) begin
            tbl_present[s] = 1'b0;
            tbl_susp[s]    = 1'b0;
            tbl_prio[s]    = '0;
            tbl_slice[s]   = '0;
        end
        tbl_run = '0;

        // Directed part.
        gen_phase = 0;
        // tick on an empty table: nothing eligible, slot 0 stays
        queue_request(pts_pkg::REQ_TICK,  4'd9,  1'b1, 1'b1, 8'hFF, 16'hFFFF, 1'b0);
        queue_request(pts_pkg::REQ_WRITE, 4'd0,  1'b1, 1'b0, 8'd1,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_WRITE, 4'd15, 1'b1, 1'b0, 8'hFF, 16'hFFFF, 1'b0);
        // suspended and absent slots with top priority must be skipped
        queue_request(pts_pkg::REQ_WRITE, 4'd7,  1'b1, 1'b1, 8'hFF, 16'd0,    1'b0);
        queue_request(pts_pkg::REQ_WRITE, 4'd3,  1'b0, 1'b1, 8'hFF, 16'd5,    1'b0);
        // empty slice on slot 0: priority drops, slot 15 wins
        queue_request(pts_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_TICK,  4'd15, 1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        // tie on priority: the later slot in scan order wins
        queue_request(pts_pkg::REQ_WRITE, 4'd5,  1'b1, 1'b0, 8'hFF, 16'd2,    1'b0);
        queue_request(pts_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        // unused request code leaves everything alone
        queue_request(REQ_UNUSED,         4'd12, 1'b1, 1'b1, 8'hAA, 16'h5555, 1'b0);
        // running slot suspended: still charged, still the starting best
        queue_request(pts_pkg::REQ_SET,   4'd7,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        // running slot absent and nothing else eligible
        queue_request(pts_pkg::REQ_WRITE, 4'd15, 1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_WRITE, 4'd5,  1'b1, 1'b1, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_WRITE, 4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_SET,   4'd3,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        // zero priority still beats an emptied running slot on a tie
        queue_request(pts_pkg::REQ_WRITE, 4'd10, 1'b1, 1'b0, 8'd0,  16'd1,    1'b0);
        queue_request(pts_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_SET,   4'd15, 1'b0, 1'b0, 8'd0,  16'd0,    1'b0);
        queue_request(pts_pkg::REQ_TICK,  4'd0,  1'b0, 1'b0, 8'd0,  16'd0,    1'b0);

        // Random part: mostly slot loads and ticks, some sets, a little noise.
        prev_phase = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            gen_phase = (i * 3) / RANDOM_ITEMS;
            // drain at each phase change, and now and then in between
            hold = (gen_phase != prev_phase) || ($urandom_range(99) < 2);
            prev_phase = gen_phase;
            sel = $urandom_range(99);
            if (sel < 40)
                rq = pts_pkg::REQ_TICK;
            else if (sel < 78)
                rq = pts_pkg::REQ_WRITE;
            else if (sel < 95)
                rq = pts_pkg::REQ_SET;
            else
                rq = REQ_UNUSED;
            // narrow priorities produce plenty of ties
            sel = $urandom_range(99);
            if (sel < 50)
                pr = 8'($urandom_range(3));
            else if (sel < 65)
                pr = 8'($urandom_range(255, 252));
            else
                pr = 8'($urandom_range(255));
            // short slices run out and zero the priority
            if ($urandom_range(99) < 60)
                sl = 16'($urandom_range(3));
            else
                sl = 16'($urandom_range(65535));
            queue_request(rq, 4'($urandom_range(15)), $urandom_range(99) < 85,
                          $urandom_range(99) < 15, pr, sl, hold);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rcvd_cnt != total_items)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (want_q.size() != 0) begin
            $display("%0d predicted results never arrived", want_q.size());
            err_cnt += want_q.size();
        end

        $display("Covered %0d requests: %0d ticks, %0d writes, %0d sets, %0d unused codes",
                 total_items, n_tick, n_write, n_set, n_unused);
        $display("%0d ticks switched the running slot; %0d drain pauses; %0d errors",
                 n_moves, n_hold, err_cnt);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_ctrl.sv
rtl/pts_dpath.sv
rtl/priority_timeslice_scheduler.sv
tb/tb_top.sv
